@@ design/agr_pkg.sv @@
`default_nettype none

package agr_pkg;

    localparam int AXES  = 3;
    localparam int ACC_W = 14;
    localparam int SQ_W  = 27;
    localparam int MAG_W = 28;
    localparam int MAX_EVENTS = 4;

    localparam logic [3:0] EV_NONE       = 4'd0;
    localparam logic [3:0] EV_TILT_UP    = 4'd1;
    localparam logic [3:0] EV_TILT_DOWN  = 4'd2;
    localparam logic [3:0] EV_TILT_LEFT  = 4'd3;
    localparam logic [3:0] EV_TILT_RIGHT = 4'd4;
    localparam logic [3:0] EV_FACE_UP    = 4'd5;
    localparam logic [3:0] EV_FACE_DOWN  = 4'd6;
    localparam logic [3:0] EV_FREEFALL   = 4'd7;
    localparam logic [3:0] EV_G3         = 4'd8;
    localparam logic [3:0] EV_G6         = 4'd9;
    localparam logic [3:0] EV_G8         = 4'd10;
    localparam logic [3:0] EV_SHAKE      = 4'd11;

    localparam logic [2:0] REG_SHAKE_TOL    = 3'd0;
    localparam logic [2:0] REG_SHAKE_LIMIT  = 3'd1;
    localparam logic [2:0] REG_FREEFALL     = 3'd2;
    localparam logic [2:0] REG_TILT_TOL     = 3'd3;
    localparam logic [2:0] REG_DAMPING      = 3'd4;
    localparam logic [2:0] REG_IMPULSE_LOW  = 3'd5;
    localparam logic [2:0] REG_IMPULSE_MID  = 3'd6;
    localparam logic [2:0] REG_IMPULSE_HIGH = 3'd7;

    localparam logic [7:0] SHAKE_REARM_TICKS = 8'd30;
    localparam logic [7:0] SHAKE_DECAY_TICKS = 8'd10;
    localparam logic signed [11:0] ONE_G = 12'sd1000;

    typedef struct packed {
        logic [12:0] shake_tolerance;
        logic [7:0]  shake_count_limit;
        logic [27:0] freefall_threshold;
        logic [9:0]  tilt_tolerance;
        logic [7:0]  gesture_damping;
        logic [27:0] impulse_low_threshold;
        logic [27:0] impulse_mid_threshold;
        logic [27:0] impulse_high_threshold;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        shake_tolerance:        13'd400,
        shake_count_limit:      8'd4,
        freefall_threshold:     28'd160000,
        tilt_tolerance:         10'd200,
        gesture_damping:        8'd5,
        impulse_low_threshold:  28'd9437184,
        impulse_mid_threshold:  28'd37748736,
        impulse_high_threshold: 28'd67108864
    };

    typedef struct packed {
        logic [SQ_W-1:0] square;
        logic            crossed;
        logic            below_lo;
        logic            above_hi;
    } lane_t;

    typedef struct packed {
        logic            over_low;
        logic            over_mid;
        logic            over_high;
        logic            freefall;
        logic [AXES-1:0] crossed;
        logic [AXES-1:0] below_lo;
        logic [AXES-1:0] above_hi;
    } feat_t;

endpackage

`default_nettype wire

@@ design/agr_sample_if.sv @@
`default_nettype none

interface agr_sample_if;
    logic                    valid;
    logic                    ready;
    logic signed [13:0]      accel_x;
    logic signed [13:0]      accel_y;
    logic signed [13:0]      accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    output ready);
endinterface

`default_nettype wire

@@ design/agr_report_if.sv @@
`default_nettype none

interface agr_report_if;
    logic       valid;
    logic       ready;
    logic [3:0] event_code;
    logic       last_event;

    modport source (output valid, output event_code, output last_event, input ready);
    modport sink   (input valid, input event_code, input last_event, output ready);
endinterface

`default_nettype wire

@@ design/agr_lane.sv @@
`default_nettype none

module agr_lane (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire logic signed [13:0] accel,
    input  wire agr_pkg::cfg_t      cfg,
    output agr_pkg::lane_t          lane
);

    logic                  pol_reg, pol_next;
    agr_pkg::lane_t        lane_reg, lane_next;

    logic signed [14:0]    acc_ext;
    logic signed [14:0]    tol;
    logic signed [11:0]    tilt;
    logic signed [11:0]    lo;
    logic signed [11:0]    hi;
    logic signed [14:0]    lo_ext;
    logic signed [14:0]    hi_ext;
    logic signed [27:0]    prod;
    logic                  crossed;

    always_comb
    begin
        acc_ext = {accel[13], accel};
        tol     = {2'b00, cfg.shake_tolerance};
        tilt    = {2'b00, cfg.tilt_tolerance};
        lo      = tilt - agr_pkg::ONE_G;
        hi      = agr_pkg::ONE_G - tilt;
        lo_ext  = {{3{lo[11]}}, lo};
        hi_ext  = {{3{hi[11]}}, hi};
        prod    = accel * accel;
        crossed = pol_reg ? (acc_ext < -tol) : (acc_ext > tol);
    end

    always_comb
    begin
        pol_next  = pol_reg;
        lane_next = lane_reg;
        if (load)
        begin
            pol_next           = pol_reg ^ crossed;
            lane_next.square   = prod[agr_pkg::SQ_W-1:0];
            lane_next.crossed  = crossed;
            lane_next.below_lo = acc_ext < lo_ext;
            lane_next.above_hi = acc_ext > hi_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pol_reg <= 1'b0;
        end
        else
        begin
            pol_reg <= pol_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lane_reg <= lane_next;
    end

    assign lane = lane_reg;

endmodule

`default_nettype wire

@@ design/agr_merge.sv @@
`default_nettype none

module agr_merge (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           lane_valid,
    input  wire agr_pkg::lane_t lane [agr_pkg::AXES],
    input  wire agr_pkg::cfg_t  cfg,
    output logic                lane_ready,
    output logic                feat_valid,
    input  wire logic           feat_ready,
    output agr_pkg::feat_t      feat
);

    logic                      valid_reg, valid_next;
    agr_pkg::feat_t            feat_reg, feat_next;
    logic [agr_pkg::MAG_W-1:0] mag;

    assign lane_ready = !valid_reg || feat_ready;

    always_comb
    begin
        mag = {1'b0, lane[0].square} + {1'b0, lane[1].square} + {1'b0, lane[2].square};
    end

    always_comb
    begin
        valid_next = valid_reg;
        feat_next  = feat_reg;
        if (lane_ready)
        begin
            valid_next = lane_valid;
            feat_next.over_low  = mag > cfg.impulse_low_threshold;
            feat_next.over_mid  = mag > cfg.impulse_mid_threshold;
            feat_next.over_high = mag > cfg.impulse_high_threshold;
            feat_next.freefall  = mag < cfg.freefall_threshold;
            for (int i = 0; i < agr_pkg::AXES; i++)
            begin
                feat_next.crossed[i]  = lane[i].crossed;
                feat_next.below_lo[i] = lane[i].below_lo;
                feat_next.above_hi[i] = lane[i].above_hi;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        feat_reg <= feat_next;
    end

    assign feat_valid = valid_reg;
    assign feat       = feat_reg;

endmodule

`default_nettype wire

@@ design/agr_track.sv @@
`default_nettype none

module agr_track (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            feat_valid,
    output logic                 feat_ready,
    input  wire agr_pkg::feat_t  feat,
    input  wire agr_pkg::cfg_t   cfg,
    agr_report_if.source         report
);

    logic [2:0] armed_reg, armed_next;
    logic [7:0] quiet_reg, quiet_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] timer_reg, timer_next;
    logic       shaken_reg, shaken_next;
    logic [7:0] hold_reg, hold_next;
    logic [3:0] cand_reg, cand_next;
    logic [3:0] rep_reg, rep_next;

    logic [3:0] evbuf_reg [agr_pkg::MAX_EVENTS];
    logic [3:0] evbuf_next [agr_pkg::MAX_EVENTS];
    logic [2:0] evlen_reg, evlen_next;
    logic [1:0] evpos_reg, evpos_next;

    logic [3:0] ev [agr_pkg::MAX_EVENTS];
    logic [2:0] n;
    logic       shake;
    logic [3:0] posture;
    logic       pop;
    logic       last_pop;
    logic       take;

    assign report.valid      = evlen_reg != 3'd0;
    assign report.event_code = evbuf_reg[evpos_reg];
    assign report.last_event = {1'b0, evpos_reg} == (evlen_reg - 3'd1);

    assign pop        = report.valid && report.ready;
    assign last_pop   = pop && report.last_event;
    assign feat_ready = !report.valid || last_pop;
    assign take       = feat_valid && feat_ready;

    always_comb
    begin
        armed_next  = armed_reg;
        quiet_next  = quiet_reg;
        count_next  = count_reg;
        timer_next  = timer_reg;
        shaken_next = shaken_reg;
        hold_next   = hold_reg;
        cand_next   = cand_reg;
        rep_next    = rep_reg;
        shake       = 1'b0;
        posture     = agr_pkg::EV_NONE;
        n           = 3'd0;
        for (int i = 0; i < agr_pkg::MAX_EVENTS; i++)
        begin
            ev[i] = agr_pkg::EV_NONE;
        end

        // impulse events, each fires once until the magnitude has gone quiet
        if (feat.over_low)
        begin
            if (!armed_next[0])
            begin
                ev[n[1:0]]    = agr_pkg::EV_G3;
                n             = n + 3'd1;
                armed_next[0] = 1'b1;
            end
            if (feat.over_mid && !armed_next[1])
            begin
                ev[n[1:0]]    = agr_pkg::EV_G6;
                n             = n + 3'd1;
                armed_next[1] = 1'b1;
            end
            if (feat.over_high && !armed_next[2])
            begin
                ev[n[1:0]]    = agr_pkg::EV_G8;
                n             = n + 3'd1;
                armed_next[2] = 1'b1;
            end
            quiet_next = 8'd0;
        end
        if (quiet_next < cfg.gesture_damping)
        begin
            quiet_next = quiet_next + 8'd1;
        end
        else
        begin
            armed_next = 3'b000;
        end

        // zero crossing count with decay and re-arm
        if ((|feat.crossed) && count_next < cfg.shake_count_limit)
        begin
            count_next = count_next + 8'd1;
            if (count_next == 8'd1)
            begin
                timer_next = 8'd0;
            end
            if (count_next == cfg.shake_count_limit)
            begin
                shaken_next = 1'b1;
                timer_next  = 8'd0;
                shake       = 1'b1;
            end
        end
        if (!shake && count_next != 8'd0)
        begin
            timer_next = timer_next + 8'd1;
            if (shaken_next && timer_next >= agr_pkg::SHAKE_REARM_TICKS)
            begin
                shaken_next = 1'b0;
                timer_next  = 8'd0;
                count_next  = 8'd0;
            end
            else if (!shaken_next && timer_next >= agr_pkg::SHAKE_DECAY_TICKS)
            begin
                timer_next = 8'd0;
                count_next = count_next - 8'd1;
            end
        end

        priority if (feat.freefall)    posture = agr_pkg::EV_FREEFALL;
        else if (feat.below_lo[0])     posture = agr_pkg::EV_TILT_LEFT;
        else if (feat.above_hi[0])     posture = agr_pkg::EV_TILT_RIGHT;
        else if (feat.below_lo[1])     posture = agr_pkg::EV_TILT_DOWN;
        else if (feat.above_hi[1])     posture = agr_pkg::EV_TILT_UP;
        else if (feat.below_lo[2])     posture = agr_pkg::EV_FACE_UP;
        else if (feat.above_hi[2])     posture = agr_pkg::EV_FACE_DOWN;
        else                           posture = agr_pkg::EV_NONE;

        // debounce: a shake reports at once, else a posture once it has held long enough
        if (shake)
        begin
            rep_next   = agr_pkg::EV_SHAKE;
            ev[n[1:0]] = agr_pkg::EV_SHAKE;
            n          = n + 3'd1;
        end
        else
        begin
            if (posture == cand_next)
            begin
                if (hold_next < cfg.gesture_damping)
                begin
                    hold_next = hold_next + 8'd1;
                end
            end
            else
            begin
                cand_next = posture;
                hold_next = 8'd0;
            end
            if (cand_next != rep_next && hold_next >= cfg.gesture_damping)
            begin
                rep_next   = cand_next;
                ev[n[1:0]] = cand_next;
                n          = n + 3'd1;
            end
        end
    end

    always_comb
    begin
        evbuf_next = evbuf_reg;
        evlen_next = evlen_reg;
        evpos_next = evpos_reg;
        if (take)
        begin
            evbuf_next = ev;
            evlen_next = n;
            evpos_next = 2'd0;
        end
        else if (last_pop)
        begin
            evlen_next = 3'd0;
            evpos_next = 2'd0;
        end
        else if (pop)
        begin
            evpos_next = evpos_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg  <= 3'b111;
            quiet_reg  <= 8'd0;
            count_reg  <= 8'd0;
            timer_reg  <= 8'd0;
            shaken_reg <= 1'b0;
            hold_reg   <= 8'd0;
            cand_reg   <= agr_pkg::EV_NONE;
            rep_reg    <= agr_pkg::EV_NONE;
            evlen_reg  <= 3'd0;
            evpos_reg  <= 2'd0;
        end
        else
        begin
            if (take)
            begin
                armed_reg  <= armed_next;
                quiet_reg  <= quiet_next;
                count_reg  <= count_next;
                timer_reg  <= timer_next;
                shaken_reg <= shaken_next;
                hold_reg   <= hold_next;
                cand_reg   <= cand_next;
                rep_reg    <= rep_next;
            end
            evlen_reg <= evlen_next;
            evpos_reg <= evpos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        evbuf_reg <= evbuf_next;
    end

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        evlen_reg <= 3'd4)
        else $error("event count out of range");

    a_empty_pos: assert property (@(posedge clk) disable iff (!rst_n)
        evlen_reg == 3'd0 |-> evpos_reg == 2'd0)
        else $error("read position left behind on empty buffer");

    a_shake_count: assert property (@(posedge clk) disable iff (!rst_n)
        shaken_reg |-> count_reg != 8'd0)
        else $error("shake reported with no crossings counted");

    a_cand_range: assert property (@(posedge clk) disable iff (!rst_n)
        cand_reg <= agr_pkg::EV_FREEFALL && rep_reg <= agr_pkg::EV_SHAKE)
        else $error("gesture code out of range");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        feat_valid && !feat_ready |=> $stable(count_reg) && $stable(rep_reg))
        else $error("tracking state moved while stalled");

endmodule

`default_nettype wire

@@ design/accel_gesture_recognizer.sv @@
// Accelerometer gesture recogniser.
// sample: one three-axis acceleration word per handshake (milli-g, signed).
// report: event words, each an event code and a flag on the final event of
//   its sample; a sample gives zero to four events, in the order g3, g6, g8,
//   then one gesture (posture, freefall, shake or return to none).
// APB port: eight registers at byte addresses 0 to 28, written in the access
//   cycle, read back at any time; pready is always high. Write only while idle.
// The events of a sample pass the lane register, the magnitude register and
//   the event buffer before the first of them is offered.
// Throughput: one sample per cycle while each gives at most one event and the
//   receiver is ready; a sample with more events holds the event buffer until
//   its final word is taken, as that buffer shows one event word per cycle.
// Reset clears all tracking state and loads the register defaults; the
//   impulse events start disarmed.
// When the receiver stalls the event buffer holds, and the two stages in front
//   of it still take up to two more samples before sample.ready drops.
`default_nettype none

module accel_gesture_recognizer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    agr_sample_if.sink       sample,
    agr_report_if.source     report,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    agr_pkg::cfg_t       cfg_reg, cfg_next;
    logic                lane_valid_reg, lane_valid_next;
    logic [2:0]          index;
    logic                wr;

    logic signed [13:0]  accel [agr_pkg::AXES];
    agr_pkg::lane_t      lane [agr_pkg::AXES];
    logic                lane_ready;
    logic                load;
    logic                feat_valid;
    logic                feat_ready;
    agr_pkg::feat_t      feat;

    assign pready = 1'b1;
    assign index  = paddr[4:2];
    assign wr     = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (index)
                agr_pkg::REG_SHAKE_TOL:    cfg_next.shake_tolerance        = pwdata[12:0];
                agr_pkg::REG_SHAKE_LIMIT:  cfg_next.shake_count_limit      = pwdata[7:0];
                agr_pkg::REG_FREEFALL:     cfg_next.freefall_threshold     = pwdata[27:0];
                agr_pkg::REG_TILT_TOL:     cfg_next.tilt_tolerance         = pwdata[9:0];
                agr_pkg::REG_DAMPING:      cfg_next.gesture_damping        = pwdata[7:0];
                agr_pkg::REG_IMPULSE_LOW:  cfg_next.impulse_low_threshold  = pwdata[27:0];
                agr_pkg::REG_IMPULSE_MID:  cfg_next.impulse_mid_threshold  = pwdata[27:0];
                agr_pkg::REG_IMPULSE_HIGH: cfg_next.impulse_high_threshold = pwdata[27:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            agr_pkg::REG_SHAKE_TOL:    prdata = {19'd0, cfg_reg.shake_tolerance};
            agr_pkg::REG_SHAKE_LIMIT:  prdata = {24'd0, cfg_reg.shake_count_limit};
            agr_pkg::REG_FREEFALL:     prdata = {4'd0, cfg_reg.freefall_threshold};
            agr_pkg::REG_TILT_TOL:     prdata = {22'd0, cfg_reg.tilt_tolerance};
            agr_pkg::REG_DAMPING:      prdata = {24'd0, cfg_reg.gesture_damping};
            agr_pkg::REG_IMPULSE_LOW:  prdata = {4'd0, cfg_reg.impulse_low_threshold};
            agr_pkg::REG_IMPULSE_MID:  prdata = {4'd0, cfg_reg.impulse_mid_threshold};
            agr_pkg::REG_IMPULSE_HIGH: prdata = {4'd0, cfg_reg.impulse_high_threshold};
        endcase
    end

    assign sample.ready = !lane_valid_reg || lane_ready;
    assign load         = sample.valid && sample.ready;

    always_comb
    begin
        lane_valid_next = lane_valid_reg;
        if (sample.ready)
        begin
            lane_valid_next = sample.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg        <= agr_pkg::CFG_RESET;
            lane_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg        <= cfg_next;
            lane_valid_reg <= lane_valid_next;
        end
    end

    assign accel[0] = sample.accel_x;
    assign accel[1] = sample.accel_y;
    assign accel[2] = sample.accel_z;

    for (genvar i = 0; i < agr_pkg::AXES; i++)
    begin : g_lane
        agr_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .load  (load),
            .accel (accel[i]),
            .cfg   (cfg_reg),
            .lane  (lane[i])
        );
    end

    agr_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .lane_valid (lane_valid_reg),
        .lane       (lane),
        .cfg        (cfg_reg),
        .lane_ready (lane_ready),
        .feat_valid (feat_valid),
        .feat_ready (feat_ready),
        .feat       (feat)
    );

    agr_track u_track (
        .clk        (clk),
        .rst_n      (rst_n),
        .feat_valid (feat_valid),
        .feat_ready (feat_ready),
        .feat       (feat),
        .cfg        (cfg_reg),
        .report     (report)
    );

endmodule

`default_nettype wire

@@ test/accel_gesture_recognizer_test.sv @@
`timescale 1ns / 1ps

module accel_gesture_recognizer_test;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 8;

    typedef struct packed {
        logic [3:0] code;
        logic       last;
    } event_word_t;

    typedef enum {HOLD_POSTURE, SHAKE_RUN, FREEFALL_RUN, IMPULSE_SPIKE, NOISE} burst_kind_t;

    class gesture_scoreboard;
        agr_pkg::cfg_t cfg;
        logic [2:0]    polarity;
        logic [7:0]    crossings;
        logic [7:0]    shake_ticks;
        logic          shake_seen;
        logic [2:0]    impulse_fired;
        logic [7:0]    quiet_ticks;
        logic [7:0]    hold_ticks;
        logic [3:0]    candidate;
        logic [3:0]    reported;
        event_word_t   awaited_events[$];
        int            mismatches;
        int            words_checked;
        int            samples_noted;
        int            code_hits[16];

        function new();
            cfg           = agr_pkg::CFG_RESET;
            polarity      = '0;
            crossings     = '0;
            shake_ticks   = '0;
            shake_seen    = 1'b0;
            impulse_fired = 3'b111;
            quiet_ticks   = '0;
            hold_ticks    = '0;
            candidate     = agr_pkg::EV_NONE;
            reported      = agr_pkg::EV_NONE;
            mismatches    = 0;
            words_checked = 0;
            samples_noted = 0;
            foreach (code_hits[k])
                code_hits[k] = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                agr_pkg::REG_SHAKE_TOL:    cfg.shake_tolerance        = value[12:0];
                agr_pkg::REG_SHAKE_LIMIT:  cfg.shake_count_limit      = value[7:0];
                agr_pkg::REG_FREEFALL:     cfg.freefall_threshold     = value[27:0];
                agr_pkg::REG_TILT_TOL:     cfg.tilt_tolerance         = value[9:0];
                agr_pkg::REG_DAMPING:      cfg.gesture_damping        = value[7:0];
                agr_pkg::REG_IMPULSE_LOW:  cfg.impulse_low_threshold  = value[27:0];
                agr_pkg::REG_IMPULSE_MID:  cfg.impulse_mid_threshold  = value[27:0];
                agr_pkg::REG_IMPULSE_HIGH: cfg.impulse_high_threshold = value[27:0];
                default: ;
            endcase
        endfunction

        function bit axis_crossed(int a, int axis);
            int tol;
            bit pol;
            tol = int'(cfg.shake_tolerance);
            pol = polarity[axis];
            if ((a < -tol && pol) || (a > tol && !pol))
            begin
                polarity[axis] = ~pol;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function logic [3:0] sort_posture(int x, int y, int z, int unsigned mag);
            bit hit;
            int lo;
            int hi;
            hit = 1'b0;
            if (axis_crossed(x, 0))
                hit = 1'b1;
            if (axis_crossed(y, 1))
                hit = 1'b1;
            if (axis_crossed(z, 2))
                hit = 1'b1;
            if (hit && crossings < cfg.shake_count_limit)
            begin
                crossings = crossings + 8'd1;
                if (crossings == 8'd1)
                    shake_ticks = '0;
                if (crossings == cfg.shake_count_limit)
                begin
                    shake_seen  = 1'b1;
                    shake_ticks = '0;
                    return agr_pkg::EV_SHAKE;
                end
            end
            if (crossings > 8'd0)
            begin
                shake_ticks = shake_ticks + 8'd1;
                if (shake_seen && shake_ticks >= agr_pkg::SHAKE_REARM_TICKS)
                begin
                    shake_seen  = 1'b0;
                    shake_ticks = '0;
                    crossings   = '0;
                end
                else if (!shake_seen && shake_ticks >= agr_pkg::SHAKE_DECAY_TICKS)
                begin
                    shake_ticks = '0;
                    crossings   = crossings - 8'd1;
                end
            end
            if (mag < cfg.freefall_threshold)
                return agr_pkg::EV_FREEFALL;
            lo = -int'(agr_pkg::ONE_G) + int'(cfg.tilt_tolerance);
            hi = int'(agr_pkg::ONE_G) - int'(cfg.tilt_tolerance);
            if (x < lo)
                return agr_pkg::EV_TILT_LEFT;
            if (x > hi)
                return agr_pkg::EV_TILT_RIGHT;
            if (y < lo)
                return agr_pkg::EV_TILT_DOWN;
            if (y > hi)
                return agr_pkg::EV_TILT_UP;
            if (z < lo)
                return agr_pkg::EV_FACE_UP;
            if (z > hi)
                return agr_pkg::EV_FACE_DOWN;
            return agr_pkg::EV_NONE;
        endfunction

        function void note_sample(logic signed [13:0] ax, logic signed [13:0] ay,
                                  logic signed [13:0] az);
            int          x;
            int          y;
            int          z;
            int unsigned mag;
            logic [3:0]  found[$];
            logic [3:0]  g;
            event_word_t w;
            x   = ax;
            y   = ay;
            z   = az;
            mag = x * x + y * y + z * z;
            samples_noted++;
            if (mag > cfg.impulse_low_threshold)
            begin
                if (!impulse_fired[0])
                begin
                    found.push_back(agr_pkg::EV_G3);
                    impulse_fired[0] = 1'b1;
                end
                if (mag > cfg.impulse_mid_threshold && !impulse_fired[1])
                begin
                    found.push_back(agr_pkg::EV_G6);
                    impulse_fired[1] = 1'b1;
                end
                if (mag > cfg.impulse_high_threshold && !impulse_fired[2])
                begin
                    found.push_back(agr_pkg::EV_G8);
                    impulse_fired[2] = 1'b1;
                end
                quiet_ticks = '0;
            end
            if (quiet_ticks < cfg.gesture_damping)
                quiet_ticks = quiet_ticks + 8'd1;
            else
                impulse_fired = '0;
            g = sort_posture(x, y, z, mag);
            if (g == agr_pkg::EV_SHAKE)
            begin
                reported = agr_pkg::EV_SHAKE;
                found.push_back(agr_pkg::EV_SHAKE);
            end
            else
            begin
                if (g == candidate)
                begin
                    if (hold_ticks < cfg.gesture_damping)
                        hold_ticks = hold_ticks + 8'd1;
                end
                else
                begin
                    candidate  = g;
                    hold_ticks = '0;
                end
                if (candidate != reported && hold_ticks >= cfg.gesture_damping)
                begin
                    reported = candidate;
                    found.push_back(reported);
                end
            end
            foreach (found[k])
            begin
                w.code = found[k];
                w.last = (k == found.size() - 1);
                awaited_events.push_back(w);
            end
        endfunction

        function void log_fault(string what, event_word_t want, logic [3:0] code,
                                logic last);
            mismatches++;
            if (mismatches <= 10)
                $display(
                    "%0t: %s at event word %0d: expected code %0d last %0b, got %0d last %0b",
                    $realtime, what, words_checked, want.code, want.last, code, last);
        endfunction

        function void check_event(logic [3:0] code, logic last);
            event_word_t want;
            words_checked++;
            code_hits[code]++;
            if (awaited_events.size() == 0)
            begin
                want = '0;
                log_fault("unexpected word", want, code, last);
            end
            else
            begin
                want = awaited_events.pop_front();
                if (want.code !== code || want.last !== last)
                    log_fault("mismatch", want, code, last);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    bit          steady;
    int          quiet_cycles;
    int          settings_applied;

    gesture_scoreboard sb = new();

    agr_sample_if sample_bus ();
    agr_report_if report_bus ();

    accel_gesture_recognizer i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (sample_bus),
        .report  (report_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [13:0] to_axis(int v);
        if (v > 8191)
            return 14'h1FFF;
        if (v < -8192)
            return 14'h2000;
        return v[13:0];
    endfunction

    task automatic send_sample(input int x, input int y, input int z);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            sample_bus.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_bus.valid   = 1'b1;
        sample_bus.accel_x = to_axis(x);
        sample_bus.accel_y = to_axis(y);
        sample_bus.accel_z = to_axis(z);
        do
            @(posedge clk);
        while (!sample_bus.ready);
        sb.note_sample(sample_bus.accel_x, sample_bus.accel_y, sample_bus.accel_z);
        @(negedge clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.write_reg(idx, value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // drop valid, drain every awaited word, then let the pipeline empty
    task automatic settle();
        sample_bus.valid = 1'b0;
        while (sb.awaited_events.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apply_setting(input agr_pkg::cfg_t c);
        settle();
        write_register(agr_pkg::REG_SHAKE_TOL,    32'(c.shake_tolerance));
        write_register(agr_pkg::REG_SHAKE_LIMIT,  32'(c.shake_count_limit));
        write_register(agr_pkg::REG_FREEFALL,     32'(c.freefall_threshold));
        write_register(agr_pkg::REG_TILT_TOL,     32'(c.tilt_tolerance));
        write_register(agr_pkg::REG_DAMPING,      32'(c.gesture_damping));
        write_register(agr_pkg::REG_IMPULSE_LOW,  32'(c.impulse_low_threshold));
        write_register(agr_pkg::REG_IMPULSE_MID,  32'(c.impulse_mid_threshold));
        write_register(agr_pkg::REG_IMPULSE_HIGH, 32'(c.impulse_high_threshold));
        settings_applied++;
    endtask

    function automatic agr_pkg::cfg_t random_setting();
        agr_pkg::cfg_t c;
        c.shake_tolerance        = 13'($urandom_range(0, 1500));
        c.shake_count_limit      = 8'($urandom_range(1, 8));
        c.freefall_threshold     = 28'($urandom_range(0, 2000000));
        c.tilt_tolerance         = 10'($urandom_range(0, 1023));
        c.gesture_damping        = 8'($urandom_range(0, 6));
        c.impulse_low_threshold  = 28'($urandom_range(0, 201326592));
        c.impulse_mid_threshold  = 28'($urandom_range(0, 201326592));
        c.impulse_high_threshold = 28'($urandom_range(0, 201326592));
        return c;
    endfunction

    task automatic run_bursts(input int count);
        int          sent;
        int          pick;
        int          len;
        int          axis;
        int          sgn;
        int          amp;
        int          v[3];
        burst_kind_t kind;
        sent = 0;
        while (sent < count)
        begin
            steady = ($urandom_range(0, 3) == 0);
            pick   = $urandom_range(0, 9);
            kind   = pick < 4 ? HOLD_POSTURE : pick < 6 ? SHAKE_RUN :
                     pick == 6 ? FREEFALL_RUN : pick == 7 ? IMPULSE_SPIKE : NOISE;
            axis   = $urandom_range(0, 2);
            sgn    = $urandom_range(0, 1) ? 1 : -1;
            len    = $urandom_range(1, 8);
            if (kind == HOLD_POSTURE)
                len = int'(sb.cfg.gesture_damping) + 1 + $urandom_range(0, 3);
            else if (kind == SHAKE_RUN)
                len = int'(sb.cfg.shake_count_limit) + $urandom_range(0, 3);
            if (len > 12)
                len = 12;
            for (int k = 0; k < len && sent < count; k++)
            begin
                case (kind)
                    HOLD_POSTURE:
                    begin
                        foreach (v[j])
                            v[j] = $urandom_range(0, 600) - 300;
                        v[axis] = sgn * 1000 + $urandom_range(0, 300) - 150;
                    end
                    SHAKE_RUN:
                    begin
                        foreach (v[j])
                            v[j] = $urandom_range(0, 200) - 100;
                        amp     = int'(sb.cfg.shake_tolerance) + 1 + $urandom_range(0, 600);
                        v[axis] = (k % 2 == 0) ? sgn * amp : -sgn * amp;
                    end
                    FREEFALL_RUN:
                    begin
                        foreach (v[j])
                            v[j] = $urandom_range(0, 500) - 250;
                    end
                    IMPULSE_SPIKE:
                    begin
                        foreach (v[j])
                            v[j] = $urandom_range(0, 16383) - 8192;
                        v[axis] = sgn * $urandom_range(3000, 8192);
                    end
                    default:
                    begin
                        foreach (v[j])
                            v[j] = $urandom_range(0, 16383) - 8192;
                    end
                endcase
                send_sample(v[0], v[1], v[2]);
                sent++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && report_bus.valid && report_bus.ready)
            sb.check_event(report_bus.event_code, report_bus.last_event);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sample_bus.valid && sample_bus.ready)
            || (report_bus.valid && report_bus.ready) || (psel && penable))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int gap;
        report_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = steady ? 0 : $urandom_range(0, 9);
            if (gap > 0)
            begin
                report_bus.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            report_bus.ready = 1'b1;
            do
                @(posedge clk);
            while (!report_bus.valid);
        end
    end

    initial
    begin
        agr_pkg::cfg_t lowest;
        agr_pkg::cfg_t highest;
        agr_pkg::cfg_t nested;
        int            kinds_seen;
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        steady             = 1'b0;
        quiet_cycles       = 0;
        settings_applied   = 0;
        sample_bus.valid   = 1'b0;
        sample_bus.accel_x = '0;
        sample_bus.accel_y = '0;
        sample_bus.accel_z = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // impulses start disarmed; extremes drive crossings into a shake
        send_sample(0, 0, 0);
        send_sample(8191, 8191, 8191);
        send_sample(-8192, -8192, -8192);
        send_sample(8191, -8192, 8191);
        send_sample(-8192, 8191, -8192);
        repeat (7) send_sample(0, 0, 0);
        send_sample(5000, 5000, 5000);

        // zero damping: each posture reports at once
        settle();
        write_register(agr_pkg::REG_DAMPING, 32'd0);
        settings_applied++;
        send_sample(-1000, 0, 0);
        send_sample(1000, 0, 0);
        send_sample(0, -1000, 0);
        send_sample(0, 1000, 0);
        send_sample(0, 0, -1000);
        send_sample(0, 0, 1000);
        send_sample(0, 0, 0);
        send_sample(500, 500, 500);
        send_sample(0, 0, 0);

        lowest  = '0;
        highest = '{
            shake_tolerance:        13'h1FFF,
            shake_count_limit:      8'hFF,
            freefall_threshold:     28'hFFFFFFF,
            tilt_tolerance:         10'h3FF,
            gesture_damping:        8'hFF,
            impulse_low_threshold:  28'hFFFFFFF,
            impulse_mid_threshold:  28'hFFFFFFF,
            impulse_high_threshold: 28'hFFFFFFF
        };
        nested = agr_pkg::CFG_RESET;
        nested.impulse_low_threshold  = 28'd60000000;
        nested.impulse_mid_threshold  = 28'd1000000;
        nested.impulse_high_threshold = 28'd2000000;
        nested.gesture_damping        = 8'd2;
        nested.shake_count_limit      = 8'd2;

        apply_setting(lowest);
        run_bursts(25);
        apply_setting(highest);
        run_bursts(25);
        apply_setting(nested);
        run_bursts(25);
        repeat (3)
        begin
            apply_setting(random_setting());
            run_bursts(25);
        end

        settle();
        kinds_seen = 0;
        for (int k = 0; k <= int'(agr_pkg::EV_SHAKE); k++)
            if (sb.code_hits[k] > 0)
                kinds_seen++;
        $display("Covered %0d samples and %0d event words over %0d register settings.",
                 sb.samples_noted, sb.words_checked, settings_applied);
        $display("Event kinds seen: %0d of 12; faults: %0d.", kinds_seen, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
